>>> rtl/core/sync_length_checksum_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit_macros.svh
// Assertion macros for the deframer; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slcd assertion failed");

// next-cycle implication
`define SLCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slcd assertion failed");

`else

`define SLCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SLCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants shared by the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slcd_pkg;

  localparam int LEN_WIDTH = 12;
  localparam int MAXL_WIDTH = 12;
  localparam int TMO_WIDTH = 8;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 12;

  localparam logic [7:0] SYNC_FIRST = 8'hAB;
  localparam logic [7:0] SYNC_SECOND = 8'hCD;
  localparam logic [MAXL_WIDTH-1:0] MAX_LENGTH_RESET = MAXL_WIDTH'(3000);
  localparam logic [TMO_WIDTH-1:0] TIMEOUT_RESET = TMO_WIDTH'(3);
  localparam logic [15:0] LEN_LIMIT = 16'((32'd1 << LEN_WIDTH) - 32'd1);

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_LENGTH = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TIMEOUT = CFG_IDX_WIDTH'(1);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    K_DATA    = 3'd0,
    K_GOOD    = 3'd1,
    K_CKERR   = 3'd2,
    K_SYNCERR = 3'd3,
    K_LENERR  = 3'd4,
    K_TIMEOUT = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    PH_HUNT  = 5'b00001,
    PH_SYNC2 = 5'b00010,
    PH_LENLO = 5'b00100,
    PH_LENHI = 5'b01000,
    PH_BODY  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [7:0]           data_byte;
    logic [LEN_WIDTH-1:0] byte_index;
    logic [LEN_WIDTH-1:0] payload_length;
  } res_t;

endpackage

>>> rtl/core/slcd_in_if.sv
// ----------------------------------------------------------------------------
// slcd_in_if
// Input channel: one received byte or one tick per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

>>> rtl/core/slcd_out_if.sv
// ----------------------------------------------------------------------------
// slcd_out_if
// Result channel: payload bytes and frame status reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     kind;
  logic [7:0]                     data_byte;
  logic [slcd_pkg::LEN_WIDTH-1:0] byte_index;
  logic [slcd_pkg::LEN_WIDTH-1:0] payload_length;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output payload_length, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input payload_length, output ready);
endinterface

>>> rtl/core/slcd_rx.sv
// ----------------------------------------------------------------------------
// slcd_rx
// Receiver state, config registers and the per-item decode/checksum step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_length_checksum_deframer_unit_macros.svh"

module slcd_rx (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step_i,
  input  logic                                opcode_i,
  input  logic [7:0]                          rx_byte_i,
  input  logic                                cfg_we_i,
  input  logic [slcd_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [slcd_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata_i,
  output slcd_pkg::res_t                      res_o
);

  localparam int LW = slcd_pkg::LEN_WIDTH;

  logic [slcd_pkg::MAXL_WIDTH-1:0] max_length_r;
  logic [slcd_pkg::TMO_WIDTH-1:0]  timeout_ticks_r;

  slcd_pkg::phase_t                phase_r, phase_nxt;
  logic [LW-1:0]                   frame_length_r, frame_length_nxt;
  logic [LW-1:0]                   byte_count_r, byte_count_nxt;
  logic [15:0]                     running_sum_r, running_sum_nxt;
  logic [7:0]                      check_low_r, check_low_nxt;
  logic [slcd_pkg::TMO_WIDTH-1:0]  idle_count_r, idle_count_nxt;

  logic [slcd_pkg::TMO_WIDTH:0]    idle_inc;
  logic [15:0]                     len_word;
  logic [LW-1:0]                   plen;
  logic [15:0]                     want_sum;
  logic                            len_bad;
  slcd_pkg::res_t                  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r    <= slcd_pkg::MAX_LENGTH_RESET;
      timeout_ticks_r <= slcd_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        slcd_pkg::CFG_MAX_LENGTH: max_length_r <= cfg_wdata_i[slcd_pkg::MAXL_WIDTH-1:0];
        slcd_pkg::CFG_TIMEOUT:    timeout_ticks_r <= cfg_wdata_i[slcd_pkg::TMO_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign idle_inc = {1'b0, idle_count_r} + 1'b1;
  assign len_word = {rx_byte_i, frame_length_r[7:0]};
  assign plen     = frame_length_r - LW'(2);
  assign want_sum = 16'd2 + running_sum_r + 16'(plen >> 8) + 16'(plen[7:0]);
  assign len_bad  = (len_word < 16'd2) ||
                    (len_word > 16'(max_length_r)) ||
                    (len_word > slcd_pkg::LEN_LIMIT);

  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    byte_count_nxt   = byte_count_r;
    running_sum_nxt  = running_sum_r;
    check_low_nxt    = check_low_r;
    idle_count_nxt   = idle_count_r;
    res              = '0;
    res.kind         = slcd_pkg::K_DATA;

    if (opcode_i == slcd_pkg::OP_TICK) begin
      if (idle_inc > (slcd_pkg::TMO_WIDTH+1)'(timeout_ticks_r)) begin
        phase_nxt        = slcd_pkg::PH_HUNT;
        frame_length_nxt = '0;
        byte_count_nxt   = '0;
        running_sum_nxt  = '0;
        check_low_nxt    = '0;
        idle_count_nxt   = '0;
        res.valid        = 1'b1;
        res.kind         = slcd_pkg::K_TIMEOUT;
      end else begin
        idle_count_nxt = idle_inc[slcd_pkg::TMO_WIDTH-1:0];
      end
    end else begin
      idle_count_nxt = '0;
      case (phase_r)
        slcd_pkg::PH_HUNT: begin
          if (rx_byte_i == slcd_pkg::SYNC_FIRST) begin
            phase_nxt = slcd_pkg::PH_SYNC2;
          end else if (rx_byte_i == slcd_pkg::SYNC_SECOND) begin
            phase_nxt = slcd_pkg::PH_LENLO;
          end else begin
            res.valid = 1'b1;
            res.kind  = slcd_pkg::K_SYNCERR;
          end
        end
        slcd_pkg::PH_SYNC2: begin
          if (rx_byte_i == slcd_pkg::SYNC_SECOND) begin
            phase_nxt = slcd_pkg::PH_LENLO;
          end else begin
            phase_nxt        = slcd_pkg::PH_HUNT;
            frame_length_nxt = '0;
            byte_count_nxt   = '0;
            running_sum_nxt  = '0;
            check_low_nxt    = '0;
            res.valid        = 1'b1;
            res.kind         = slcd_pkg::K_SYNCERR;
          end
        end
        slcd_pkg::PH_LENLO: begin
          frame_length_nxt = LW'(rx_byte_i);
          phase_nxt        = slcd_pkg::PH_LENHI;
        end
        slcd_pkg::PH_LENHI: begin
          byte_count_nxt  = '0;
          running_sum_nxt = '0;
          check_low_nxt   = '0;
          if (len_bad) begin
            phase_nxt        = slcd_pkg::PH_HUNT;
            frame_length_nxt = '0;
            res.valid        = 1'b1;
            res.kind         = slcd_pkg::K_LENERR;
          end else begin
            frame_length_nxt = len_word[LW-1:0];
            phase_nxt        = slcd_pkg::PH_BODY;
          end
        end
        slcd_pkg::PH_BODY: begin
          if (byte_count_r < plen) begin
            running_sum_nxt    = running_sum_r + 16'(rx_byte_i);
            byte_count_nxt     = byte_count_r + 1'b1;
            res.valid          = 1'b1;
            res.kind           = slcd_pkg::K_DATA;
            res.data_byte      = rx_byte_i;
            res.byte_index     = byte_count_r;
            res.payload_length = plen;
          end else if (byte_count_r == plen) begin
            check_low_nxt  = rx_byte_i;
            byte_count_nxt = byte_count_r + 1'b1;
          end else begin
            phase_nxt          = slcd_pkg::PH_HUNT;
            frame_length_nxt   = '0;
            byte_count_nxt     = '0;
            running_sum_nxt    = '0;
            check_low_nxt      = '0;
            res.valid          = 1'b1;
            res.kind           = ({rx_byte_i, check_low_r} == want_sum) ?
                                 slcd_pkg::K_GOOD : slcd_pkg::K_CKERR;
            res.payload_length = plen;
          end
        end
        default: begin
          phase_nxt        = slcd_pkg::PH_HUNT;
          frame_length_nxt = '0;
          byte_count_nxt   = '0;
          running_sum_nxt  = '0;
          check_low_nxt    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= slcd_pkg::PH_HUNT;
      frame_length_r <= '0;
      byte_count_r   <= '0;
      running_sum_r  <= '0;
      check_low_r    <= '0;
      idle_count_r   <= '0;
    end else if (step_i) begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      byte_count_r   <= byte_count_nxt;
      running_sum_r  <= running_sum_nxt;
      check_low_r    <= check_low_nxt;
      idle_count_r   <= idle_count_nxt;
    end
  end

  assign res_o = res;

  `SLCD_ASSERT_IMP(a_body_len_min, clk, rst_n, phase_r == slcd_pkg::PH_BODY,
                   frame_length_r >= LW'(2))
  `SLCD_ASSERT_IMP(a_body_count_bound, clk, rst_n, phase_r == slcd_pkg::PH_BODY,
                   byte_count_r <= frame_length_r - LW'(1))
  `SLCD_ASSERT_NXT(a_timeout_clears, clk, rst_n,
                   step_i && opcode_i == slcd_pkg::OP_TICK && res.valid,
                   phase_r == slcd_pkg::PH_HUNT && idle_count_r == '0)

endmodule

>>> rtl/core/sync_length_checksum_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit
// Length-prefixed frame receiver with additive 16-bit checksum.
// ----------------------------------------------------------------------------
// Path: an input transfer goes into the input register, and its report
//   then into the result register.
// Throughput: one item per cycle unless a report waits on a held result.
// Reset: synchronous, active low; receiver hunts for sync, config registers
//   return to max_length 3000 and timeout_ticks 3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_length_checksum_deframer_unit_macros.svh"

module sync_length_checksum_deframer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  slcd_in_if.sink                             in_if,
  slcd_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [slcd_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [slcd_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata
);

  logic           s1_valid_r;
  logic           s1_opcode_r;
  logic [7:0]     s1_byte_r;
  logic           out_valid_r;
  slcd_pkg::res_t out_r;
  slcd_pkg::res_t res;
  logic           out_free;
  logic           advance;
  logic           in_xfer;

  slcd_rx u_rx (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (advance),
    .opcode_i    (s1_opcode_r),
    .rx_byte_i   (s1_byte_r),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .res_o       (res)
  );

  assign out_free    = !out_valid_r || out_if.ready;
  assign advance     = s1_valid_r && (!res.valid || out_free);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_xfer     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_opcode_r <= in_if.opcode;
      s1_byte_r   <= in_if.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_r <= res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = out_r.kind;
  assign out_if.data_byte      = out_r.data_byte;
  assign out_if.byte_index     = out_r.byte_index;
  assign out_if.payload_length = out_r.payload_length;

  `SLCD_ASSERT_NXT(a_s1_hold, clk, rst_n, s1_valid_r && !advance, s1_valid_r)
  `SLCD_ASSERT_IMP(a_status_zero, clk, rst_n,
                   out_valid_r && out_r.kind != slcd_pkg::K_DATA,
                   out_r.data_byte == '0 && out_r.byte_index == '0)
  `SLCD_ASSERT_IMP(a_index_in_frame, clk, rst_n,
                   out_valid_r && out_r.kind == slcd_pkg::K_DATA,
                   out_r.byte_index < out_r.payload_length)

endmodule

>>> tb/deframer_check.sv
// ----------------------------------------------------------------------------
// deframer_check
// Watches the byte/tick and report channels of the deframer, keeps a
// behavioral copy of the receiver and config registers, predicts each report
// and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deframer_check import slcd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  slcd_in_if                        in_mon,
  slcd_out_if                       out_mon,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  input  logic                      run_done,
  output int                        pending,
  output int                        fail_count
);

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           data_byte;
    logic [LEN_WIDTH-1:0] byte_index;
    logic [LEN_WIDTH-1:0] payload_length;
  } report_t;

  logic [MAXL_WIDTH-1:0] max_len_q;
  logic [TMO_WIDTH-1:0]  tmo_q;
  phase_t                ph;
  logic [LEN_WIDTH-1:0]  flen;
  logic [LEN_WIDTH-1:0]  nbytes;
  logic [15:0]           csum;
  logic [7:0]            ck_lo;
  logic [7:0]            idle_ticks;
  report_t               expected_reports[$];
  int                    fails = 0;
  int                    n_waiting = 0;

  assign fail_count = fails;
  assign pending = n_waiting;

  function automatic void drop_frame();
    ph = PH_HUNT;
    flen = '0;
    nbytes = '0;
    csum = '0;
    ck_lo = '0;
  endfunction

  // Advances the receiver by one byte or tick; returns 1 when a report results.
  function automatic bit step_receiver(input logic op, input logic [7:0] b,
                                       output report_t rep);
    logic [8:0]           ticks;
    logic [15:0]          len;
    logic [LEN_WIDTH-1:0] plen;
    logic [15:0]          want;
    rep = '0;
    if (op == OP_TICK) begin
      ticks = {1'b0, idle_ticks} + 9'd1;
      if (ticks > {1'b0, tmo_q}) begin
        drop_frame();
        idle_ticks = '0;
        rep.kind = K_TIMEOUT;
        return 1'b1;
      end
      idle_ticks = ticks[7:0];
      return 1'b0;
    end
    idle_ticks = '0;
    case (ph)
      PH_HUNT: begin
        if (b == SYNC_FIRST) begin
          ph = PH_SYNC2;
        end else if (b == SYNC_SECOND) begin
          ph = PH_LENLO;
        end else begin
          rep.kind = K_SYNCERR;
          return 1'b1;
        end
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          ph = PH_LENLO;
        end else begin
          drop_frame();
          rep.kind = K_SYNCERR;
          return 1'b1;
        end
      end
      PH_LENLO: begin
        flen = LEN_WIDTH'(b);
        ph = PH_LENHI;
      end
      PH_LENHI: begin
        len = {b, flen[7:0]};
        if (len < 16'd2 || len > 16'(max_len_q) || len > LEN_LIMIT) begin
          drop_frame();
          rep.kind = K_LENERR;
          return 1'b1;
        end
        flen = len[LEN_WIDTH-1:0];
        nbytes = '0;
        csum = '0;
        ck_lo = '0;
        ph = PH_BODY;
      end
      PH_BODY: begin
        plen = flen - LEN_WIDTH'(2);
        if (nbytes < plen) begin
          rep.kind = K_DATA;
          rep.data_byte = b;
          rep.byte_index = nbytes;
          rep.payload_length = plen;
          csum = csum + 16'(b);
          nbytes = nbytes + 1'b1;
          return 1'b1;
        end
        if (nbytes == plen) begin
          ck_lo = b;
          nbytes = nbytes + 1'b1;
          return 1'b0;
        end
        want = 16'd2 + csum + 16'(plen >> 8) + 16'(plen[7:0]);
        rep.kind = ({b, ck_lo} == want) ? K_GOOD : K_CKERR;
        rep.payload_length = plen;
        drop_frame();
        return 1'b1;
      end
      default: drop_frame();
    endcase
    return 1'b0;
  endfunction

  function automatic int field_diff(input string name, input logic [31:0] exp_val,
                                    input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    report_t rep;
    report_t want_rep;
    if (!rst_n) begin
      max_len_q = MAX_LENGTH_RESET;
      tmo_q = TIMEOUT_RESET;
      drop_frame();
      idle_ticks = '0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_LENGTH) begin
          max_len_q = cfg_wdata[MAXL_WIDTH-1:0];
        end else if (cfg_index == CFG_TIMEOUT) begin
          tmo_q = cfg_wdata[TMO_WIDTH-1:0];
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (step_receiver(in_mon.opcode, in_mon.rx_byte, rep)) begin
          expected_reports.push_back(rep);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report transfer: kind %0d", out_mon.kind);
          fails++;
        end else begin
          want_rep = expected_reports.pop_front();
          fails += field_diff("kind", 32'(want_rep.kind), 32'(out_mon.kind));
          fails += field_diff("data_byte", 32'(want_rep.data_byte), 32'(out_mon.data_byte));
          fails += field_diff("byte_index", 32'(want_rep.byte_index),
                              32'(out_mon.byte_index));
          fails += field_diff("payload_length", 32'(want_rep.payload_length),
                              32'(out_mon.payload_length));
        end
      end
      if (run_done && expected_reports.size() != 0) begin
        $error("%0d expected reports never arrived", expected_reports.size());
        fails += expected_reports.size();
        expected_reports.delete();
      end
    end
    n_waiting = expected_reports.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives framed byte streams, ticks and config writes into the deframer:
// a short set of corner cases, then random frames, corrupted frames, noise
// and timeouts under several register settings, with random stalls on both
// channels. The checker instance does all the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import slcd_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata;
  logic                      run_done;
  int                        pending;
  int                        fail_count;
  bit                        calm;
  int                        sent;
  logic [MAXL_WIDTH-1:0]     max_len_now;
  logic [TMO_WIDTH-1:0]      tmo_now;

  slcd_in_if  in_if ();
  slcd_out_if out_if ();

  sync_length_checksum_deframer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  deframer_check frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .run_done   (run_done),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_if.ready <= calm || ($urandom_range(99) >= 29);
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

  // One transfer on the input channel; called and returns at a falling edge.
  task automatic feed(input logic op, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 29) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int plen, input bit good, input bit lone);
    logic [15:0] sum;
    logic [7:0]  b;
    int          len;
    len = plen + 2;
    sum = 16'(2 + (plen >> 8) + (plen & 255));
    if (!lone) feed(OP_BYTE, SYNC_FIRST);
    feed(OP_BYTE, SYNC_SECOND);
    feed(OP_BYTE, 8'(len));
    feed(OP_BYTE, 8'(len >> 8));
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom);
      sum = sum + 16'(b);
      feed(OP_BYTE, b);
    end
    if (!good) sum = sum ^ 16'($urandom_range(65535, 1));
    feed(OP_BYTE, sum[7:0]);
    feed(OP_BYTE, sum[15:8]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [MAXL_WIDTH-1:0] maxl,
                           input logic [TMO_WIDTH-1:0] tmo);
    write_reg(CFG_MAX_LENGTH, maxl);
    write_reg(CFG_TIMEOUT, {4'($urandom), tmo});
    max_len_now = maxl;
    tmo_now = tmo;
  endtask

  // Hold the sender until every report is in, then let the pipeline drain.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic random_phase(input int budget);
    int          start;
    int          pick;
    int          plen;
    int          cap;
    int          len;
    int          part;
    start = sent;
    cap = (max_len_now >= 2) ? int'(max_len_now) - 2 : 0;
    while (sent - start < budget) begin
      pick = $urandom_range(99);
      plen = $urandom_range(($urandom_range(19) == 0) ? 200 : 12, 0);
      if (max_len_now >= 2 && plen > cap) plen = cap;
      if (pick < 55) begin
        send_frame(plen, 1'b1, 1'($urandom));
      end else if (pick < 65) begin
        send_frame(plen, 1'b0, 1'($urandom));
      end else if (pick < 78) begin
        feed(OP_TICK, 8'($urandom));
      end else if (pick < 88) begin
        feed(OP_BYTE, 8'($urandom));
      end else if (pick < 94) begin
        case ($urandom_range(3))
          0: len = 0;
          1: len = 1;
          2: len = int'(max_len_now) + 1;
          default: len = $urandom_range(65535);
        endcase
        feed(OP_BYTE, SYNC_SECOND);
        feed(OP_BYTE, 8'(len));
        feed(OP_BYTE, 8'(len >> 8));
      end else begin
        // frame cut short, then left idle until the receiver gives up
        part = $urandom_range(plen + 1);
        feed(OP_BYTE, SYNC_SECOND);
        feed(OP_BYTE, 8'(plen + 2));
        feed(OP_BYTE, 8'((plen + 2) >> 8));
        repeat (part) feed(OP_BYTE, 8'($urandom));
        repeat (int'(tmo_now) + 1) feed(OP_TICK, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_BYTE;
    in_if.rx_byte = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    run_done = 1'b0;
    calm = 1'b0;
    sent = 0;
    max_len_now = MAX_LENGTH_RESET;
    tmo_now = TIMEOUT_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corner cases at reset settings
    feed(OP_BYTE, 8'h00);
    feed(OP_BYTE, SYNC_FIRST);
    feed(OP_BYTE, 8'hFF);
    feed(OP_BYTE, SYNC_SECOND);
    feed(OP_BYTE, 8'h01);
    feed(OP_BYTE, 8'h00);
    send_frame(0, 1'b1, 1'b1);
    send_frame(1, 1'b0, 1'b1);
    feed(OP_BYTE, SYNC_SECOND);
    feed(OP_BYTE, 8'hFF);
    feed(OP_BYTE, 8'hFF);
    repeat (4) feed(OP_TICK, 8'($urandom));
    settle();

    random_phase(250);
    settle();

    calm = 1'b1;
    configure(MAXL_WIDTH'(4095), TMO_WIDTH'(255));
    send_frame(120, 1'b1, 1'b0);
    random_phase(80);
    settle();
    calm = 1'b0;

    configure(MAXL_WIDTH'(2), TMO_WIDTH'(0));
    random_phase(150);
    settle();

    configure(MAXL_WIDTH'(1), TMO_WIDTH'(1));
    random_phase(100);
    settle();

    write_reg(CFG_IDX_WIDTH'(2), CFG_DATA_WIDTH'($urandom));
    write_reg(CFG_IDX_WIDTH'(3), CFG_DATA_WIDTH'($urandom));
    configure(MAXL_WIDTH'(40), TMO_WIDTH'(8));
    random_phase(250);
    settle();

    configure(MAXL_WIDTH'($urandom_range(4095, 2)), TMO_WIDTH'($urandom_range(12)));
    random_phase(150);
    settle();

    run_done <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
